@@ hdl/dtfx_pkg.sv @@
package dtfx_pkg;

	// Number format
	localparam int FRAC_BITS       = 32;
	localparam int MAX_FRAC_DIGITS = 9;
	localparam int INT_W           = 64 - FRAC_BITS;
	localparam int FCNT_W          = 4;

	localparam logic [63:0]      MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [INT_W+3:0] INT_LIMIT = (INT_W + 4)'(MAG_MAX >> FRAC_BITS);

	// Weight of the k-th fraction digit: round(2^FRAC_BITS / 10^k)
	localparam logic [FRAC_BITS-1:0] FRAC_WEIGHT [0:9] = '{
		FRAC_BITS'(0),
		FRAC_BITS'(((65'd1 << (FRAC_BITS + 1)) / 65'd10 + 65'd1) >> 1),
		FRAC_BITS'(((65'd1 << (FRAC_BITS + 1)) / 65'd100 + 65'd1) >> 1),
		FRAC_BITS'(((65'd1 << (FRAC_BITS + 1)) / 65'd1000 + 65'd1) >> 1),
		FRAC_BITS'(((65'd1 << (FRAC_BITS + 1)) / 65'd10000 + 65'd1) >> 1),
		FRAC_BITS'(((65'd1 << (FRAC_BITS + 1)) / 65'd100000 + 65'd1) >> 1),
		FRAC_BITS'(((65'd1 << (FRAC_BITS + 1)) / 65'd1000000 + 65'd1) >> 1),
		FRAC_BITS'(((65'd1 << (FRAC_BITS + 1)) / 65'd10000000 + 65'd1) >> 1),
		FRAC_BITS'(((65'd1 << (FRAC_BITS + 1)) / 65'd100000000 + 65'd1) >> 1),
		FRAC_BITS'(((65'd1 << (FRAC_BITS + 1)) / 65'd1000000000 + 65'd1) >> 1)
	};

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	// Token queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		TK_SPACE,
		TK_PLUS,
		TK_MINUS,
		TK_DIGIT,
		TK_POINT,
		TK_OTHER
	} tok_class_t;

	typedef struct packed {
		tok_class_t cls;
		logic [3:0] digit;
		logic       eot;
	} token_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

endpackage

@@ hdl/dtfx_in_if.sv @@
interface dtfx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

@@ hdl/dtfx_out_if.sv @@
interface dtfx_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic               saturated;

	modport source (output valid, output value, output saturated, input ready);
	modport sink (input valid, input value, input saturated, output ready);
endinterface

@@ hdl/decimal_text_to_fixed_point.sv @@
// Decimal text to signed fixed point converter.
// text_in takes one character word per cycle (char_code, end_of_text) under
// valid/ready. Leading whitespace, an optional sign, integer digits and an
// optional point with fraction digits form the number; the first character
// that does not fit, or end_of_text, produces one word on num_out: value in
// 64-bit two's complement with FRAC_BITS fraction bits, and saturated when
// the integer part was clamped. Characters after a result are dropped until
// end_of_text, which rearms the parser.
// Throughput: one character per cycle while the queue has room. A classifier
// writes tokens into a four-entry queue; the parser pops one token per cycle
// unless the queue is empty or stage 1 cannot take a result, and feeds a
// two-stage output register (magnitude, then sign); stage 2 drives num_out.
// Reset clears the parser, the queue and the output valid flags; num_out.valid
// is low after reset. When the receiver holds ready low, the output word
// holds, the parser runs on until a result finds both output stages full,
// and text_in.ready falls once the queue is full.
module decimal_text_to_fixed_point (
	input logic        clk,
	input logic        arst_n,
	dtfx_in_if.sink    text_in,
	dtfx_out_if.source num_out
);
	import dtfx_pkg::*;

	q_stat_t q_stat;
	token_t  tok_front;
	token_t  tok_head;
	logic    push;
	logic    pop;

	dtfx_front u_front (
		.text_in (text_in),
		.q_stat  (q_stat),
		.push    (push),
		.tok     (tok_front)
	);

	dtfx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.tok_in  (tok_front),
		.pop     (pop),
		.tok_out (tok_head),
		.q_stat  (q_stat)
	);

	dtfx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok     (tok_head),
		.q_stat  (q_stat),
		.pop     (pop),
		.num_out (num_out)
	);

	// A clamped result is always the largest magnitude
	assert property (@(posedge clk) disable iff (!arst_n)
		num_out.valid && num_out.saturated |->
			(num_out.value == 64'sh7FFF_FFFF_FFFF_FFFF) ||
			(num_out.value == -64'sh7FFF_FFFF_FFFF_FFFF))
	else $error("saturated result without clamped value");

	// The parser never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
	else $error("token queue underflow");

	// The fill count stays within the queue depth
	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QDEPTH))
	else $error("token queue overflow");

endmodule

@@ hdl/dtfx_front.sv @@
module dtfx_front (
	dtfx_in_if.sink           text_in,
	input  dtfx_pkg::q_stat_t q_stat,
	output logic              push,
	output dtfx_pkg::token_t  tok
);
	import dtfx_pkg::*;

	// Take a word whenever the queue has room
	assign text_in.ready = !q_stat.full;
	assign push          = text_in.valid && !q_stat.full;

	// Classify the character
	always_comb begin
		tok.eot   = text_in.end_of_text;
		tok.digit = 4'(text_in.char_code - CH_ZERO);
		if (text_in.char_code inside {[CH_TAB:CH_CR], CH_SPACE}) begin
			tok.cls = TK_SPACE;
		end else if (text_in.char_code inside {[CH_ZERO:CH_NINE]}) begin
			tok.cls = TK_DIGIT;
		end else if (text_in.char_code == CH_PLUS) begin
			tok.cls = TK_PLUS;
		end else if (text_in.char_code == CH_MINUS) begin
			tok.cls = TK_MINUS;
		end else if (text_in.char_code == CH_POINT) begin
			tok.cls = TK_POINT;
		end else begin
			tok.cls = TK_OTHER;
		end
	end

endmodule

@@ hdl/dtfx_queue.sv @@
module dtfx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dtfx_pkg::token_t  tok_in,
	input  logic              pop,
	output dtfx_pkg::token_t  tok_out,
	output dtfx_pkg::q_stat_t q_stat
);
	import dtfx_pkg::*;

	token_t             slot_q [QDEPTH];
	logic  [QPTR_W-1:0] wr_ptr_q;
	logic  [QPTR_W-1:0] rd_ptr_q;
	logic  [QCNT_W-1:0] count_q;

	// Store tokens
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= tok_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign tok_out      = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign q_stat.count = count_q;

endmodule

@@ hdl/dtfx_back.sv @@
module dtfx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dtfx_pkg::token_t  tok,
	input  dtfx_pkg::q_stat_t q_stat,
	output logic              pop,
	dtfx_out_if.source        num_out
);
	import dtfx_pkg::*;

	typedef enum logic [3:0] {
		PH_LEAD = 4'b0001,
		PH_INT  = 4'b0010,
		PH_FRAC = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	phase_t              phase_q, phase_n;
	logic                neg_q, neg_n;
	logic [63:0]         acc_q, acc_n;
	logic [FCNT_W-1:0]   cnt_q, cnt_n;
	logic                clamp_q, clamp_n;
	logic                ended;
	logic                emit;

	logic [INT_W-1:0]    ip;
	logic [INT_W+3:0]    cand;
	logic [63:0]         int_acc;
	logic                int_clamp;

	logic [FCNT_W-1:0]   cnt_inc;
	logic [FRAC_BITS+3:0] prod;
	logic [64:0]         sum;
	logic [63:0]         frac_acc;
	logic [FCNT_W-1:0]   frac_cnt;

	logic                v_s1;
	logic [63:0]         mag_s1;
	logic                neg_s1;
	logic                sat_s1;
	logic                move_s1;
	logic                free_s1;

	logic                v_s2;
	logic [63:0]         value_s2;
	logic                sat_s2;

	// Integer digit: ip * 10 + d, clamp past the limit
	always_comb begin
		ip   = acc_q[63:FRAC_BITS];
		cand = ({4'b0, ip} << 3) + ({4'b0, ip} << 1) + (INT_W + 4)'(tok.digit);
		if (clamp_q) begin
			int_acc   = acc_q;
			int_clamp = 1'b1;
		end else if (cand > INT_LIMIT) begin
			int_acc   = MAG_MAX;
			int_clamp = 1'b1;
		end else begin
			int_acc   = {cand[INT_W-1:0], {FRAC_BITS{1'b0}}};
			int_clamp = 1'b0;
		end
	end

	// Fraction digit: add d times the weight of its place
	always_comb begin
		cnt_inc  = cnt_q + FCNT_W'(1);
		prod     = (FRAC_BITS + 4)'(tok.digit) * (FRAC_BITS + 4)'(FRAC_WEIGHT[cnt_inc]);
		sum      = {1'b0, acc_q} + 65'(prod);
		frac_acc = acc_q;
		frac_cnt = cnt_q;
		if (cnt_q < FCNT_W'(MAX_FRAC_DIGITS)) begin
			frac_cnt = cnt_inc;
			if (!clamp_q) begin
				frac_acc = (sum > 65'(MAG_MAX)) ? MAG_MAX : sum[63:0];
			end
		end
	end

	// Parse step for the token at the head of the queue
	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		clamp_n = clamp_q;
		ended   = 1'b0;
		case (phase_q)
			PH_LEAD: begin
				case (tok.cls)
					TK_SPACE: ;
					TK_PLUS: begin
						phase_n = PH_INT;
					end
					TK_MINUS: begin
						phase_n = PH_INT;
						neg_n   = 1'b1;
					end
					TK_DIGIT: begin
						phase_n = PH_INT;
						acc_n   = int_acc;
						clamp_n = int_clamp;
					end
					TK_POINT: begin
						phase_n = PH_FRAC;
					end
					default: ended = 1'b1;
				endcase
			end
			PH_INT: begin
				case (tok.cls)
					TK_DIGIT: begin
						acc_n   = int_acc;
						clamp_n = int_clamp;
					end
					TK_POINT: begin
						phase_n = PH_FRAC;
					end
					default: ended = 1'b1;
				endcase
			end
			PH_FRAC: begin
				if (tok.cls == TK_DIGIT) begin
					acc_n = frac_acc;
					cnt_n = frac_cnt;
				end else begin
					ended = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign emit = (phase_q != PH_DONE) && (ended || tok.eot);

	// Output pipeline flow: s1 holds the magnitude, s2 the signed word
	assign move_s1 = v_s1 && (!v_s2 || num_out.ready);
	assign free_s1 = !v_s1 || move_s1;
	assign pop     = !q_stat.empty && (!emit || free_s1);

	// Parser state: rearm at end of text, hold in done after a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= '0;
			clamp_q <= 1'b0;
		end else if (pop) begin
			if (tok.eot) begin
				phase_q <= PH_LEAD;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				cnt_q   <= '0;
				clamp_q <= 1'b0;
			end else if (emit) begin
				phase_q <= PH_DONE;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				cnt_q   <= cnt_n;
				clamp_q <= clamp_n;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pop && emit) begin
			v_s1 <= 1'b1;
		end else if (move_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			mag_s1 <= acc_n;
			neg_s1 <= neg_n;
			sat_s1 <= clamp_n;
		end
	end

	// Stage 2 valid: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (move_s1) begin
			v_s2 <= 1'b1;
		end else if (num_out.ready) begin
			v_s2 <= 1'b0;
		end
	end

	// Stage 2 payload: apply the sign
	always_ff @(posedge clk) begin
		if (move_s1) begin
			value_s2 <= neg_s1 ? (64'd0 - mag_s1) : mag_s1;
			sat_s2   <= sat_s1;
		end
	end

	assign num_out.valid     = v_s2;
	assign num_out.value     = value_s2;
	assign num_out.saturated = sat_s2;

endmodule
